/* rtl/hcr_pkg.sv */
package hcr_pkg;

  // Geometry
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int WIN           = 5;
  localparam int STORE_ROWS    = 4;
  localparam int QUEUE_DEPTH   = 2;

  // Field widths
  localparam int GRAD_W   = 8;
  localparam int PIX_W    = 16;
  localparam int WIDTH_W  = 11;
  localparam int ROW_W    = 16;
  localparam int COL_OUT_W = 10;
  localparam int K_W      = 16;
  localparam int RESP_W   = 53;
  localparam int ACC_W    = 25;
  localparam int MUL_W    = 26;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARRIS_K     = 2'd2;

  // Register reset values
  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RST = 16'd480;
  localparam logic [K_W-1:0]     HARRIS_K_RST     = 16'd2621;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN-1:0][WIN-1:0] win_t;

  // One window waiting for the response datapath
  typedef struct packed {
    win_t                   win;
    logic [ROW_W-1:0]       row;
    logic [COL_OUT_W-1:0]   col;
  } job_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_READ,
    FR_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ACC,
    BK_M1,
    BK_M2,
    BK_M3,
    BK_M4,
    BK_M5,
    BK_FIN,
    BK_OUT
  } back_state_t;

  // Separable smoothing weight of one tap position
  function automatic logic [2:0] tap_weight(input logic [2:0] idx);
    logic [2:0] w;
    case (idx)
      3'd0, 3'd4: w = 3'd3;
      3'd1, 3'd3: w = 3'd5;
      3'd2:       w = 3'd4;
      default:    w = 3'd0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/harris_corner_response_unit.sv */
// Channel  Direction  Payload (low bit up)
// s_*      in         tdata: grad_x_abs[7:0], grad_y_abs[15:8]
// m_*      out        tdata: response[52:0], center_row[68:53], center_col[78:69], pad
// cfg_*    in         index 0 image_width, 1 image_height, 2 harris_k_q16
//
// Front takes a new pixel only when idle, after the line store read and any window push.
// Back handles one window at a time: 25 taps through the product/sum stage, five passes
// through one shared 26x26 multiplier and a final subtract, then the result handshake.
// A 2-entry window queue lets front and back stall apart.
// Reset is synchronous; counters and window clear, line store holds no reset.
module harris_corner_response_unit #(
  parameter int MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // grad_x_abs, grad_y_abs
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [79:0]                     m_tdata,   // response, center_row, center_col
  input  logic                            cfg_we,
  input  logic [hcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hcr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [hcr_pkg::WIDTH_W-1:0]   image_width;
  logic [hcr_pkg::ROW_W-1:0]     image_height;
  logic [hcr_pkg::K_W-1:0]       harris_k_q16;

  hcr_pkg::pix_t                 pix_in;
  logic                          push;
  hcr_pkg::job_t                 push_job;
  logic                          full;
  logic                          pop;
  hcr_pkg::job_t                 pop_job;
  logic                          empty;
  logic [hcr_pkg::RESP_W-1:0]    response;
  logic [hcr_pkg::ROW_W-1:0]     center_row;
  logic [hcr_pkg::COL_OUT_W-1:0] center_col;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= hcr_pkg::IMAGE_WIDTH_RST;
      image_height <= hcr_pkg::IMAGE_HEIGHT_RST;
      harris_k_q16 <= hcr_pkg::HARRIS_K_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hcr_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[hcr_pkg::WIDTH_W-1:0];
        hcr_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[hcr_pkg::ROW_W-1:0];
        hcr_pkg::CFG_HARRIS_K:     harris_k_q16 <= cfg_data[hcr_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  // Internal pixel word keeps dx in the high byte
  assign pix_in = {s_tdata[7:0], s_tdata[15:8]};

  hcr_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .pix_valid    (s_tvalid),
    .pix_ready    (s_tready),
    .pix_in       (pix_in),
    .push         (push),
    .push_job     (push_job),
    .full         (full)
  );

  hcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  hcr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .harris_k_q16 (harris_k_q16),
    .empty        (empty),
    .pop_job      (pop_job),
    .pop          (pop),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready),
    .response     (response),
    .center_row   (center_row),
    .center_col   (center_col)
  );

  assign m_tdata = {1'b0, center_col, center_row, response};

endmodule

/* rtl/hcr_ram.sv */
module hcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/hcr_queue.sv */
module hcr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hcr_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output hcr_pkg::job_t pop_job,
  output logic          empty
);

  localparam int PTR_W = $clog2(hcr_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(hcr_pkg::QUEUE_DEPTH + 1);

  hcr_pkg::job_t    slots [hcr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(hcr_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  // Store a job
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/hcr_front.sv */
module hcr_front #(
  parameter int MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [hcr_pkg::WIDTH_W-1:0]  image_width,
  input  logic [hcr_pkg::ROW_W-1:0]    image_height,
  input  logic                         pix_valid,
  output logic                         pix_ready,
  input  hcr_pkg::pix_t                pix_in,
  output logic                         push,
  output hcr_pkg::job_t                push_job,
  input  logic                         full
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int UW_W  = COL_W + 1;

  hcr_pkg::front_state_t state, state_next;

  logic [COL_W-1:0]              col;
  logic [hcr_pkg::ROW_W-1:0]     row;
  logic [COL_W-1:0]              cur_col;
  logic [hcr_pkg::ROW_W-1:0]     cur_row;
  hcr_pkg::pix_t                 cur_pix;
  hcr_pkg::win_t                 win;
  hcr_pkg::pix_t                 rd [hcr_pkg::STORE_ROWS];

  logic [UW_W-1:0]               used_w;
  logic [hcr_pkg::ROW_W-1:0]     used_h;
  logic                          accept;
  logic [COL_W-1:0]              in_col;
  logic [hcr_pkg::ROW_W-1:0]     in_row;
  logic [UW_W-1:0]               col_inc;
  logic [hcr_pkg::ROW_W-1:0]     in_row_inc;
  logic [hcr_pkg::ROW_W-1:0]     row_inc;
  logic                          emit;
  logic [hcr_pkg::ROW_W-1:0]     col_ext;

  // Next row, wrapping at the frame end
  function automatic logic [hcr_pkg::ROW_W-1:0] step_row(
    input logic [hcr_pkg::ROW_W-1:0] r,
    input logic [hcr_pkg::ROW_W-1:0] h
  );
    logic [hcr_pkg::ROW_W:0] r1;
    r1 = {1'b0, r} + 1'b1;
    return (r1 >= {1'b0, h}) ? '0 : r1[hcr_pkg::ROW_W-1:0];
  endfunction

  // Clamp the frame size
  always_comb begin
    if (image_width < hcr_pkg::WIDTH_W'(5)) begin
      used_w = UW_W'(5);
    end else if (32'(image_width) > MAX_WIDTH) begin
      used_w = UW_W'(MAX_WIDTH);
    end else begin
      used_w = UW_W'(image_width);
    end
    used_h = (image_height < hcr_pkg::ROW_W'(5)) ? hcr_pkg::ROW_W'(5) : image_height;
  end

  assign pix_ready = (state == hcr_pkg::FR_IDLE);
  assign accept    = pix_valid && pix_ready;

  // Close a row first if the width was lowered under the counter
  always_comb begin
    in_row_inc = step_row(row, used_h);
    if ({1'b0, col} >= used_w) begin
      in_col = '0;
      in_row = in_row_inc;
    end else begin
      in_col = col;
      in_row = row;
    end
    col_inc = {1'b0, in_col} + 1'b1;
    row_inc = step_row(in_row, used_h);
  end

  // Line store: one memory per stored row
  for (genvar s = 0; s < hcr_pkg::STORE_ROWS; s++) begin : g_line
    hcr_ram #(
      .WIDTH (hcr_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (accept && (in_row[1:0] == 2'(s))),
      .waddr (in_col),
      .wdata (pix_in),
      .raddr (in_col),
      .rdata (rd[s])
    );
  end

  assign emit    = (cur_row >= hcr_pkg::ROW_W'(4)) && (cur_col >= COL_W'(4));
  assign col_ext = hcr_pkg::ROW_W'(cur_col) - hcr_pkg::ROW_W'(2);

  assign push         = (state == hcr_pkg::FR_PUSH) && !full;
  assign push_job.win = win;
  assign push_job.row = cur_row - hcr_pkg::ROW_W'(2);
  assign push_job.col = col_ext[hcr_pkg::COL_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcr_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hcr_pkg::FR_IDLE: begin
        if (accept) begin
          state_next = hcr_pkg::FR_READ;
        end
      end
      hcr_pkg::FR_READ: begin
        state_next = emit ? hcr_pkg::FR_PUSH : hcr_pkg::FR_IDLE;
      end
      hcr_pkg::FR_PUSH: begin
        if (!full) begin
          state_next = hcr_pkg::FR_IDLE;
        end
      end
      default: state_next = hcr_pkg::FR_IDLE;
    endcase
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_inc >= used_w) begin
        col <= '0;
        row <= row_inc;
      end else begin
        col <= col_inc[COL_W-1:0];
        row <= in_row;
      end
    end
  end

  // Hold the accepted pixel and its position
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_col <= in_col;
      cur_row <= in_row;
      cur_pix <= pix_in;
    end
  end

  // Shift the new column into the window
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (state == hcr_pkg::FR_READ) begin
      for (int i = 0; i < hcr_pkg::WIN; i++) begin
        for (int j = 0; j < hcr_pkg::WIN - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
      end
      for (int i = 0; i < hcr_pkg::STORE_ROWS; i++) begin
        win[i][hcr_pkg::WIN-1] <= rd[2'(cur_row[1:0] + 2'(i))];
      end
      win[hcr_pkg::WIN-1][hcr_pkg::WIN-1] <= cur_pix;
    end
  end

endmodule

/* rtl/hcr_back.sv */
module hcr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hcr_pkg::K_W-1:0]       harris_k_q16,
  input  logic                          empty,
  input  hcr_pkg::job_t                 pop_job,
  output logic                          pop,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [hcr_pkg::RESP_W-1:0]    response,
  output logic [hcr_pkg::ROW_W-1:0]     center_row,
  output logic [hcr_pkg::COL_OUT_W-1:0] center_col
);

  localparam int PROD_W = 2 * hcr_pkg::MUL_W;
  localparam int KP_W   = hcr_pkg::K_W + hcr_pkg::MUL_W;
  localparam int KT_W   = KP_W + hcr_pkg::MUL_W;
  localparam int DIFF_W = hcr_pkg::RESP_W + 1;

  hcr_pkg::back_state_t state, state_next;

  hcr_pkg::job_t                job;
  logic [2:0]                   ti;
  logic [2:0]                   tj;
  logic                         tap_done;
  logic                         s1v;
  logic [hcr_pkg::PIX_W-1:0]    sqx;
  logic [hcr_pkg::PIX_W-1:0]    sqy;
  logic [hcr_pkg::PIX_W-1:0]    sxy;
  logic [4:0]                   wt;
  logic [hcr_pkg::ACC_W-1:0]    pxx;
  logic [hcr_pkg::ACC_W-1:0]    pyy;
  logic [hcr_pkg::ACC_W-1:0]    pxy;
  logic [PROD_W-1:0]            p1;
  logic [PROD_W-1:0]            p2;
  logic [PROD_W-1:0]            t2;
  logic [KP_W-1:0]              klo;
  logic [KP_W-1:0]              khi;

  hcr_pkg::pix_t                tap;
  logic [hcr_pkg::GRAD_W-1:0]   dx;
  logic [hcr_pkg::GRAD_W-1:0]   dy;
  logic [hcr_pkg::MUL_W-1:0]    ma;
  logic [hcr_pkg::MUL_W-1:0]    mb;
  logic [PROD_W-1:0]            prod;
  logic [KT_W-1:0]              kt_full;
  logic [DIFF_W-1:0]            diff;

  assign tap = job.win[ti][tj];
  assign dx  = tap[hcr_pkg::PIX_W-1:hcr_pkg::GRAD_W];
  assign dy  = tap[hcr_pkg::GRAD_W-1:0];

  assign pop       = (state == hcr_pkg::BK_IDLE) && !empty;
  assign res_valid = (state == hcr_pkg::BK_OUT);

  // Shared multiplier
  always_comb begin
    case (state)
      hcr_pkg::BK_M1: begin
        ma = hcr_pkg::MUL_W'(pxx);
        mb = hcr_pkg::MUL_W'(pyy);
      end
      hcr_pkg::BK_M2: begin
        ma = hcr_pkg::MUL_W'(pxy);
        mb = hcr_pkg::MUL_W'(pxy);
      end
      hcr_pkg::BK_M3: begin
        ma = hcr_pkg::MUL_W'(pxx) + hcr_pkg::MUL_W'(pyy);
        mb = hcr_pkg::MUL_W'(pxx) + hcr_pkg::MUL_W'(pyy);
      end
      hcr_pkg::BK_M4: begin
        ma = hcr_pkg::MUL_W'(harris_k_q16);
        mb = t2[hcr_pkg::MUL_W-1:0];
      end
      hcr_pkg::BK_M5: begin
        ma = hcr_pkg::MUL_W'(harris_k_q16);
        mb = t2[PROD_W-1:hcr_pkg::MUL_W];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = PROD_W'(ma) * PROD_W'(mb);
  end

  // Combine k*trace^2 halves, drop 16 fraction bits, subtract from det
  always_comb begin
    kt_full = {khi, {hcr_pkg::MUL_W{1'b0}}} + KT_W'(klo);
    diff    = DIFF_W'(p1) - DIFF_W'(p2) - DIFF_W'(kt_full[KT_W-1:hcr_pkg::K_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcr_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hcr_pkg::BK_IDLE: if (!empty) state_next = hcr_pkg::BK_ACC;
      hcr_pkg::BK_ACC:  if (tap_done && !s1v) state_next = hcr_pkg::BK_M1;
      hcr_pkg::BK_M1:   state_next = hcr_pkg::BK_M2;
      hcr_pkg::BK_M2:   state_next = hcr_pkg::BK_M3;
      hcr_pkg::BK_M3:   state_next = hcr_pkg::BK_M4;
      hcr_pkg::BK_M4:   state_next = hcr_pkg::BK_M5;
      hcr_pkg::BK_M5:   state_next = hcr_pkg::BK_FIN;
      hcr_pkg::BK_FIN:  state_next = hcr_pkg::BK_OUT;
      hcr_pkg::BK_OUT:  if (res_ready) state_next = hcr_pkg::BK_IDLE;
      default:          state_next = hcr_pkg::BK_IDLE;
    endcase
  end

  // Tap walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      ti       <= '0;
      tj       <= '0;
      tap_done <= 1'b0;
      s1v      <= 1'b0;
    end else if (state == hcr_pkg::BK_IDLE) begin
      ti       <= '0;
      tj       <= '0;
      tap_done <= 1'b0;
      s1v      <= 1'b0;
    end else if (state == hcr_pkg::BK_ACC) begin
      s1v <= !tap_done;
      if (!tap_done) begin
        if (tj == 3'd4) begin
          tj <= '0;
          if (ti == 3'd4) begin
            tap_done <= 1'b1;
          end else begin
            ti <= ti + 1'b1;
          end
        end else begin
          tj <= tj + 1'b1;
        end
      end
    end
  end

  // Datapath: products, weighted sums, response
  always_ff @(posedge clk) begin
    case (state)
      hcr_pkg::BK_IDLE: begin
        job <= pop_job;
        pxx <= '0;
        pyy <= '0;
        pxy <= '0;
      end
      hcr_pkg::BK_ACC: begin
        sqx <= hcr_pkg::PIX_W'(dx) * hcr_pkg::PIX_W'(dx);
        sqy <= hcr_pkg::PIX_W'(dy) * hcr_pkg::PIX_W'(dy);
        sxy <= hcr_pkg::PIX_W'(dx) * hcr_pkg::PIX_W'(dy);
        wt  <= 5'(hcr_pkg::tap_weight(ti)) * 5'(hcr_pkg::tap_weight(tj));
        if (s1v) begin
          pxx <= pxx + hcr_pkg::ACC_W'(sqx) * hcr_pkg::ACC_W'(wt);
          pyy <= pyy + hcr_pkg::ACC_W'(sqy) * hcr_pkg::ACC_W'(wt);
          pxy <= pxy + hcr_pkg::ACC_W'(sxy) * hcr_pkg::ACC_W'(wt);
        end
      end
      hcr_pkg::BK_M1: p1  <= prod;
      hcr_pkg::BK_M2: p2  <= prod;
      hcr_pkg::BK_M3: t2  <= prod;
      hcr_pkg::BK_M4: klo <= prod[KP_W-1:0];
      hcr_pkg::BK_M5: khi <= prod[KP_W-1:0];
      hcr_pkg::BK_FIN: begin
        response   <= diff[hcr_pkg::RESP_W-1:0];
        center_row <= job.row;
        center_col <= job.col;
      end
      default: ;
    endcase
  end

endmodule
